>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the deframer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define RPD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define RPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rpd_pkg.sv
// ---------------------------------------------------------------------------
// rpd_pkg
// Shared constants, codes and types of the packet deframer.
// ---------------------------------------------------------------------------
package rpd_pkg;

   // Payload length at which the packet is dropped as an overflow
   localparam int unsigned MAX_PAYLOAD = 128;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned KIND_W = 2;

   // Framing characters
   localparam logic [BYTE_W-1:0] CH_START = 8'h24;  // '$'
   localparam logic [BYTE_W-1:0] CH_END   = 8'h23;  // '#'

   // Result codes
   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_BAD      = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   // One result transaction
   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] packet_length;
      logic [BYTE_W-1:0] command_byte;
   } rsp_item_type;

   // Registered received byte handed to the core
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } beat_type;

   // Result handed from the core to the output buffer
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } result_type;

endpackage

>>> rtl/rpd_if.sv
// ---------------------------------------------------------------------------
// rpd_if
// Valid/ready channels for received bytes and deframer results.
// ---------------------------------------------------------------------------
interface rpd_req_if import rpd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rpd_rsp_if import rpd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] payload_byte;
   logic [BYTE_W-1:0] packet_length;
   logic [BYTE_W-1:0] command_byte;

   modport source (output valid, output kind, output payload_byte,
                   output packet_length, output command_byte, input ready);
   modport sink   (input valid, input kind, input payload_byte,
                   input packet_length, input command_byte, output ready);
endinterface

>>> rtl/rpd_in_stage.sv
// ---------------------------------------------------------------------------
// rpd_in_stage
// Input register: captures one received byte per transaction.
// ---------------------------------------------------------------------------
module rpd_in_stage import rpd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rpd_req_if.sink   req_bus,
   input  logic      take,
   output beat_type  beat
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic              accept;

   // Accept when empty or when the held byte moves on this cycle
   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   // Hold the byte until the core takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         data_ff <= req_bus.rx_byte;
      end
   end

   assign beat.valid = valid_ff;
   assign beat.data  = data_ff;

endmodule

>>> rtl/rpd_core.sv
// ---------------------------------------------------------------------------
// rpd_core
// Framing state machine: running checksum, byte count and verdicts.
// ---------------------------------------------------------------------------
module rpd_core import rpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  beat_type   beat,
   input  logic       take,
   output result_type result
);

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_DATA = 2'd1,
      PH_HIGH = 2'd2,
      PH_LOW  = 2'd3
   } phase_type;

   phase_type         phase_ff,       phase_in;
   logic [BYTE_W-1:0] sum_ff,         sum_in;
   logic [BYTE_W-1:0] count_ff,       count_in;
   logic [BYTE_W-1:0] first_ff,       first_in;
   logic [3:0]        high_ff,        high_in;
   logic              digit_err_ff,   digit_err_in;

   logic [BYTE_W-1:0] c;
   logic [BYTE_W-1:0] count_next;
   logic [BYTE_W-1:0] first_next;
   logic [4:0]        digit;
   logic              bad;
   logic [BYTE_W-1:0] rx_sum;
   rsp_item_type      item;
   logic              res_valid;

   // Decode a lowercase hex digit: {bad, value}
   function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] ch);
      logic is_dec;
      logic is_hex;
      is_dec = (ch >= 8'h30) && (ch <= 8'h39);
      is_hex = (ch >= 8'h61) && (ch <= 8'h66);
      if (is_dec) begin
         hex_nibble = {1'b0, ch[3:0]};
      end else if (is_hex) begin
         hex_nibble = {1'b0, ch[3:0] + 4'd9};
      end else begin
         hex_nibble = 5'b10000;
      end
   endfunction

   assign c          = beat.data;
   assign count_next = count_ff + 8'd1;
   assign first_next = (count_ff == '0) ? c : first_ff;
   assign digit      = hex_nibble(c);
   assign bad        = digit[4] || digit_err_ff;
   assign rx_sum     = {high_ff, digit[3:0]};

   // Work out next state and the result for the byte in the input register
   always_comb begin
      phase_in     = phase_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      high_in      = high_ff;
      digit_err_in = digit_err_ff;
      res_valid    = 1'b0;
      item         = '{kind: KIND_PAYLOAD, payload_byte: '0,
                       packet_length: '0, command_byte: '0};
      case (phase_ff)
         PH_HUNT: begin
            if (c == CH_START) begin
               sum_in       = '0;
               count_in     = '0;
               first_in     = '0;
               high_in      = '0;
               digit_err_in = 1'b0;
               phase_in     = PH_DATA;
            end
         end
         PH_DATA: begin
            if (c == CH_END) begin
               phase_in = PH_HIGH;
            end else begin
               first_in  = first_next;
               sum_in    = sum_ff + c;
               count_in  = count_next;
               res_valid = 1'b1;
               if (count_next >= BYTE_W'(MAX_PAYLOAD)) begin
                  item.kind          = KIND_OVERFLOW;
                  item.packet_length = count_next;
                  item.command_byte  = first_next;
                  phase_in           = PH_HUNT;
               end else begin
                  item.payload_byte = c;
               end
            end
         end
         PH_HIGH: begin
            high_in      = digit[3:0];
            digit_err_in = digit[4];
            phase_in     = PH_LOW;
         end
         PH_LOW: begin
            res_valid          = 1'b1;
            item.kind          = (!bad && (rx_sum == sum_ff)) ? KIND_GOOD : KIND_BAD;
            item.packet_length = count_ff;
            item.command_byte  = first_ff;
            phase_in           = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // Advance state only when a byte is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         sum_ff       <= '0;
         count_ff     <= '0;
         first_ff     <= '0;
         high_ff      <= '0;
         digit_err_ff <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         high_ff      <= high_in;
         digit_err_ff <= digit_err_in;
      end
   end

   assign result.valid = take && res_valid;
   assign result.item  = item;

endmodule

>>> rtl/rpd_out_buffer.sv
// ---------------------------------------------------------------------------
// rpd_out_buffer
// Two-entry result buffer: registers results and parts the two sides.
// ---------------------------------------------------------------------------
module rpd_out_buffer import rpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       full,
   rpd_rsp_if.source  rsp_bus
);

   rsp_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff,  count_in;
   logic         pop;
   logic         push;
   rsp_item_type head;

   assign full = (count_ff == 2'd2);
   assign push = result.valid;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Advance pointers and store each new result
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= result.item;
      end
   end

   assign head                  = entry_ff[rd_ptr_ff];
   assign rsp_bus.valid         = (count_ff != '0);
   assign rsp_bus.kind          = head.kind;
   assign rsp_bus.payload_byte  = head.payload_byte;
   assign rsp_bus.packet_length = head.packet_length;
   assign rsp_bus.command_byte  = head.command_byte;

endmodule

>>> rtl/rsp_packet_deframer_unit.sv
// Path: the core decodes the held byte as it takes it and the buffer registers the result.
// Throughput: one received byte per cycle; the core takes a byte whenever the
// two-entry result buffer is not full, so a stalled sink stops intake once
// two results wait. Bytes that give no result leave the buffer untouched.
// Reset: synchronous, active high; clears the framing phase, the byte holding
// register and the result buffer, and the block hunts for a start character.
// ---------------------------------------------------------------------------
// rsp_packet_deframer_unit
// Deframes serial debug packets, passes payload and checks the checksum.
// ---------------------------------------------------------------------------
module rsp_packet_deframer_unit import rpd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rpd_req_if.sink   req_bus,
   rpd_rsp_if.source rsp_bus
);

   beat_type   beat;
   result_type result;
   logic       full;
   logic       take;

   // Move the held byte into the core when the result side has room
   assign take = beat.valid && !full;

   rpd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .take    (take),
      .beat    (beat)
   );

   rpd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .beat   (beat),
      .take   (take),
      .result (result)
   );

   rpd_out_buffer u_out_buffer (
      .clock   (clock),
      .reset   (reset),
      .result  (result),
      .full    (full),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> rtl/rpd_checker.sv
// ---------------------------------------------------------------------------
// rpd_checker
// Port-level checks on the deframer result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rpd_checker import rpd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] rsp_kind,
   input logic [BYTE_W-1:0] rsp_payload_byte,
   input logic [BYTE_W-1:0] rsp_packet_length,
   input logic [BYTE_W-1:0] rsp_command_byte
);

   `RPD_ASSERT_ALWAYS(a_idle_after_reset, clock, ($past(reset) && !reset) |-> !rsp_valid, "result after reset")
   `RPD_ASSERT(a_payload_clean, clock, reset, (rsp_valid && (rsp_kind == KIND_PAYLOAD)) |-> ((rsp_packet_length == '0) && (rsp_command_byte == '0)), "payload result carries verdict fields")
   `RPD_ASSERT(a_verdict_clean, clock, reset, (rsp_valid && (rsp_kind != KIND_PAYLOAD)) |-> ((rsp_payload_byte == '0) && (rsp_packet_length <= BYTE_W'(MAX_PAYLOAD))), "verdict result malformed")
   `RPD_ASSERT(a_overflow_len, clock, reset, (rsp_valid && (rsp_kind == KIND_OVERFLOW)) |-> (rsp_packet_length == BYTE_W'(MAX_PAYLOAD)), "overflow length wrong")
   `RPD_ASSERT(a_stall_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_packet_length)), "stalled result changed")

endmodule

bind rsp_packet_deframer_unit rpd_checker u_rpd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_kind          (rsp_bus.kind),
   .rsp_payload_byte  (rsp_bus.payload_byte),
   .rsp_packet_length (rsp_bus.packet_length),
   .rsp_command_byte  (rsp_bus.command_byte)
);
